// ===== design/sqc_pkg.sv =====
`timescale 1ns / 1ps

package sqc_pkg;

   // Default width of the running cycle total.
   localparam int unsigned CYCLE_BITS_DEFAULT = 64;

   // Register file layout.
   localparam int unsigned REG_COUNT    = 6;
   localparam int unsigned REG_IDX_BITS = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_SWEEP   = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_LENGTH  = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_ENVELOPE = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_FREQ_LO = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_FREQ_HI = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_STATUS  = 3'd5;

   // Timing units. Every period is a whole number of length frames.
   localparam int unsigned FRAME_CYCLES  = 4194304 / 256;
   localparam int unsigned FRAME_SHIFT   = $clog2(FRAME_CYCLES);
   localparam int unsigned SWEEP_FRAMES  = (4194304 / 128) / FRAME_CYCLES;
   localparam int unsigned ENV_FRAMES    = (4194304 / 64) / FRAME_CYCLES;
   localparam int unsigned FREQ_LIMIT    = 2048;

   // The frame count is kept modulo a number that every sweep period
   // (2..14 frames) and every envelope period (4..28 frames) divides.
   localparam int unsigned RESIDUE_MOD  = 420 * ENV_FRAMES;
   localparam int unsigned RES_BITS     = $clog2(RESIDUE_MOD);

   // Divisor width for the shared remainder unit (largest period is 28 frames).
   localparam int unsigned DIV_BITS     = $clog2(7 * ENV_FRAMES + 1);

   // Frames added by one advance: at most four.
   localparam int unsigned STEP_BITS    = 3;

   typedef enum logic [1:0] {
      CMD_ADVANCE = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_READ    = 2'd2
   } sqc_cmd_type;

   // Fields of the register file that the sequencer and the outputs look at.
   typedef struct packed {
      logic        run;
      logic [2:0]  sweep_pace;
      logic [2:0]  sweep_exp;
      logic [2:0]  env_length;
      logic [3:0]  volume;
      logic [10:0] frequency;
      logic        status_on;
   } sqc_view_type;

   // Which units act on the current advance.
   typedef struct packed {
      logic sweep;
      logic length;
      logic envelope;
   } sqc_hits_type;

   // Frame count residue of 2^(bits - FRAME_SHIFT), the amount that leaves
   // the frame count when the cycle total wraps. Used at elaboration only.
   function automatic int unsigned wrap_residue(input int unsigned bits);
      int unsigned r;
      r = 1;
      for (int unsigned i = 0; i < bits - FRAME_SHIFT; i++) begin
         r = r * 2;
         if (r >= RESIDUE_MOD) begin
            r = r - RESIDUE_MOD;
         end
      end
      return r;
   endfunction

endpackage

// ===== design/sqc_channels.sv =====
`timescale 1ns / 1ps

// Request channel: one word per command.
interface sqc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [2:0]  reg_index;
   logic [7:0]  write_data;
   logic [15:0] cycles;

   modport source (output valid, command, reg_index, write_data, cycles, input ready);
   modport sink   (input valid, command, reg_index, write_data, cycles, output ready);
endinterface

// Response channel: one word per command.
interface sqc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        channel_running;
   logic [3:0]  volume;
   logic [10:0] frequency;
   logic        status_on;

   modport source (output valid, read_data, channel_running, volume, frequency, status_on,
                   input ready);
   modport sink   (input valid, read_data, channel_running, volume, frequency, status_on,
                   output ready);
endinterface

// ===== design/square_channel_sweep_length_envelope_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake    Payload
// req_ch    in   valid/ready  command, reg_index, write_data, cycles
// rsp_ch    out  valid/ready  read_data, channel_running, volume, frequency, status_on
//
// Writes, reads and advances with the run bit clear do not use the remainder unit.
// An advance while running uses the shared remainder unit twice, 11 bit
// steps each, once for the sweep period and once for the envelope.
// Reset is synchronous; all registers and the cycle total read as zero after it.
// A result waits in the output register while the next word is taken in;
// the next result is held back until that register is free.
module square_channel_sweep_length_envelope_unit
   import sqc_pkg::*;
#(
   parameter int unsigned CYCLE_COUNTER_BITS = CYCLE_BITS_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   sqc_req_if.sink       req_ch,
   sqc_rsp_if.source     rsp_ch
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_SWEEP = 5'b00100,
      ST_ENV   = 5'b01000,
      ST_DONE  = 5'b10000
   } sqc_state_type;

   sqc_state_type state_ff, state_in;

   logic [1:0]              cmd_ff, cmd_in;
   logic [REG_IDX_BITS-1:0] index_ff, index_in;
   logic [7:0]              data_ff, data_in;
   logic [15:0]             cycles_ff, cycles_in;
   logic                    sweep_hit_ff, sweep_hit_in;

   logic                    out_valid_ff, out_valid_in;
   logic [7:0]              out_read_ff, out_read_in;
   sqc_view_type            out_view_ff, out_view_in;

   logic                    accept;
   logic                    out_load;

   logic                    unit_start;
   logic [DIV_BITS-1:0]     unit_divisor;
   logic                    unit_done;
   logic                    unit_crossed;

   logic [RES_BITS-1:0]     residue;
   logic [STEP_BITS-1:0]    step;
   logic                    wrap;
   logic                    tb_clear;
   logic                    tb_update;

   logic                    reg_wr;
   logic                    reg_apply;
   sqc_hits_type            hits;
   logic [7:0]              rd_data;
   sqc_view_type            view;

   logic [DIV_BITS-1:0]     sweep_div;
   logic [DIV_BITS-1:0]     env_div;
   logic                    sweep_en;
   logic                    env_en;

   assign accept = req_ch.valid && req_ch.ready;

   // Periods in frames for the two variable units.
   assign sweep_div = DIV_BITS'(view.sweep_pace) * DIV_BITS'(SWEEP_FRAMES);
   assign env_div   = DIV_BITS'(view.env_length) * DIV_BITS'(ENV_FRAMES);
   assign sweep_en  = (view.sweep_pace != 3'd0) && (view.sweep_exp != 3'd0);
   assign env_en    = (view.env_length != 3'd0);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      index_in     = index_ff;
      data_in      = data_ff;
      cycles_in    = cycles_ff;
      sweep_hit_in = sweep_hit_ff;
      unit_start   = 1'b0;
      unit_divisor = sweep_div;
      tb_clear     = 1'b0;
      tb_update    = 1'b0;
      reg_wr       = 1'b0;
      reg_apply    = 1'b0;
      hits         = '0;
      out_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_ch.command;
               index_in  = req_ch.reg_index;
               data_in   = req_ch.write_data;
               cycles_in = req_ch.cycles;
               state_in  = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DONE;
            if (cmd_ff == CMD_ADVANCE) begin
               if (view.run) begin
                  unit_start = 1'b1;
                  state_in   = ST_SWEEP;
               end else begin
                  tb_clear = 1'b1;
               end
            end else if (cmd_ff == CMD_WRITE) begin
               reg_wr = 1'b1;
            end
         end
         ST_SWEEP: begin
            if (unit_done) begin
               sweep_hit_in = sweep_en && unit_crossed && !wrap;
               unit_start   = 1'b1;
               unit_divisor = env_div;
               state_in     = ST_ENV;
            end
         end
         ST_ENV: begin
            unit_divisor = env_div;
            if (unit_done) begin
               hits.sweep    = sweep_hit_ff;
               hits.length   = (step != '0) && !wrap;
               hits.envelope = env_en && unit_crossed && !wrap;
               reg_apply     = 1'b1;
               tb_update     = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      out_read_in  = out_read_ff;
      out_view_in  = out_view_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_read_in  = (cmd_ff == CMD_READ) ? rd_data : 8'h00;
         out_view_in  = view;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff       <= cmd_in;
      index_ff     <= index_in;
      data_ff      <= data_in;
      cycles_ff    <= cycles_in;
      sweep_hit_ff <= sweep_hit_in;
      out_read_ff  <= out_read_in;
      out_view_ff  <= out_view_in;
   end

   sqc_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .dividend (residue),
      .divisor  (unit_divisor),
      .addend   (step),
      .done     (unit_done),
      .crossed  (unit_crossed)
   );

   sqc_timebase #(
      .CYCLE_COUNTER_BITS (CYCLE_COUNTER_BITS)
   ) u_timebase (
      .clock   (clock),
      .reset   (reset),
      .cycles  (cycles_ff),
      .clear   (tb_clear),
      .update  (tb_update),
      .residue (residue),
      .step    (step),
      .wrap    (wrap)
   );

   sqc_regfile u_regs (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (reg_wr),
      .index   (index_ff),
      .wr_data (data_ff),
      .apply   (reg_apply),
      .hits    (hits),
      .rd_data (rd_data),
      .view    (view)
   );

   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.read_data       = out_read_ff;
   assign rsp_ch.channel_running = out_view_ff.run;
   assign rsp_ch.volume          = out_view_ff.volume;
   assign rsp_ch.frequency       = out_view_ff.frequency;
   assign rsp_ch.status_on       = out_view_ff.status_on;

endmodule

// ===== design/sqc_rem_unit.sv =====
`timescale 1ns / 1ps

// Shared restoring remainder unit. It takes the frame residue apart one bit
// a cycle against a period, then tells whether adding the frame step to that
// remainder reaches the period, i.e. whether a period boundary is crossed.
module sqc_rem_unit
   import sqc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RES_BITS-1:0]   dividend,
   input  logic [DIV_BITS-1:0]   divisor,
   input  logic [STEP_BITS-1:0]  addend,
   output logic                  done,
   output logic                  crossed
);

   localparam int unsigned CNT_BITS = $clog2(RES_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(RES_BITS - 1);

   logic                 running_ff, running_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [RES_BITS-1:0]  dvd_ff, dvd_in;
   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [DIV_BITS-1:0]  divisor_ff, divisor_in;
   logic [STEP_BITS-1:0] addend_ff, addend_in;

   logic [DIV_BITS:0]    trial;
   logic [DIV_BITS:0]    diff;
   logic [DIV_BITS:0]    reach;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial      = {rem_ff, dvd_ff[RES_BITS-1]};
      diff       = trial - {1'b0, divisor_ff};
      running_in = running_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      addend_in  = addend_ff;
      if (start) begin
         running_in = 1'b1;
         count_in   = '0;
         dvd_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         addend_in  = addend;
      end else if (running_ff) begin
         rem_in   = (trial >= {1'b0, divisor_ff}) ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
         dvd_in   = {dvd_ff[RES_BITS-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      addend_ff  <= addend_in;
   end

   // A boundary is crossed when remainder plus step reaches the period.
   assign reach   = {1'b0, rem_ff} + (DIV_BITS + 1)'(addend_ff);
   assign crossed = (reach >= {1'b0, divisor_ff});
   assign done    = done_ff;

endmodule

// ===== design/sqc_timebase.sv =====
`timescale 1ns / 1ps

// Running cycle total and the frame count residue kept beside it.
module sqc_timebase
   import sqc_pkg::*;
#(
   parameter int unsigned CYCLE_COUNTER_BITS = CYCLE_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           cycles,
   input  logic                  clear,
   input  logic                  update,
   output logic [RES_BITS-1:0]   residue,
   output logic [STEP_BITS-1:0]  step,
   output logic                  wrap
);

   localparam int unsigned N      = CYCLE_COUNTER_BITS;
   localparam int unsigned RES_W  = RES_BITS + 1;
   localparam int unsigned WRAP_C = wrap_residue(CYCLE_COUNTER_BITS);
   localparam int unsigned WRAP_K = (WRAP_C == 0) ? 0 : RESIDUE_MOD - WRAP_C;
   localparam logic [RES_W-1:0] MOD_W = RES_W'(RESIDUE_MOD);

   logic [N-1:0]            total_ff, total_in;
   logic [RES_BITS-1:0]     residue_ff, residue_in;

   logic [N:0]              sum;
   logic [FRAME_SHIFT+2:0]  frac_sum;
   logic [RES_W-1:0]        r1, r1m, r2, r2m;

   // Wide add of the advance, and the carry out of the frame fraction.
   assign sum      = {1'b0, total_ff} + (N + 1)'(cycles);
   assign frac_sum = {3'b000, total_ff[FRAME_SHIFT-1:0]} + (FRAME_SHIFT + 3)'(cycles);
   assign step     = frac_sum[FRAME_SHIFT+2:FRAME_SHIFT];
   assign wrap     = sum[N];

   // Residue update: add the frames, and on a wrap take out what left the total.
   always_comb begin
      r1  = {1'b0, residue_ff} + RES_W'(step);
      r1m = (r1 >= MOD_W) ? r1 - MOD_W : r1;
      r2  = r1m + (wrap ? RES_W'(WRAP_K) : '0);
      r2m = (r2 >= MOD_W) ? r2 - MOD_W : r2;
      total_in   = total_ff;
      residue_in = residue_ff;
      if (clear) begin
         total_in   = '0;
         residue_in = '0;
      end else if (update) begin
         total_in   = sum[N-1:0];
         residue_in = r2m[RES_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         residue_ff <= '0;
      end else begin
         total_ff   <= total_in;
         residue_ff <= residue_in;
      end
   end

   assign residue = residue_ff;

endmodule

// ===== design/sqc_regfile.sv =====
`timescale 1ns / 1ps

// The six channel registers with the sweep, length and envelope updates.
module sqc_regfile
   import sqc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [REG_IDX_BITS-1:0]  index,
   input  logic [7:0]               wr_data,
   input  logic                     apply,
   input  sqc_hits_type             hits,
   output logic [7:0]               rd_data,
   output sqc_view_type             view
);

   logic [7:0]  regs_ff [REG_COUNT];
   logic [7:0]  regs_in [REG_COUNT];

   logic [10:0] freq;
   logic [10:0] delta;
   logic [11:0] sweep_sum;
   logic [5:0]  len;
   logic [3:0]  vol;
   logic        env_up;

   assign freq   = {regs_ff[REG_FREQ_HI][2:0], regs_ff[REG_FREQ_LO]};
   assign delta  = freq >> regs_ff[REG_SWEEP][2:0];
   assign len    = regs_ff[REG_LENGTH][5:0];
   assign vol    = regs_ff[REG_ENVELOPE][7:4];
   assign env_up = regs_ff[REG_ENVELOPE][3];

   // Sweep moves the frequency down when the decrease bit is set.
   assign sweep_sum = regs_ff[REG_SWEEP][3] ? {1'b0, freq} - {1'b0, delta}
                                            : {1'b0, freq} + {1'b0, delta};

   always_comb begin
      regs_in = regs_ff;
      if (wr_en && (index < REG_IDX_BITS'(REG_COUNT))) begin
         regs_in[index] = wr_data;
      end
      if (apply) begin
         // Sweep: overflow past the limit stops the channel.
         if (hits.sweep) begin
            if (sweep_sum >= 12'(FREQ_LIMIT)) begin
               regs_in[REG_FREQ_HI][7] = 1'b0;
            end else begin
               regs_in[REG_FREQ_HI][2:0] = sweep_sum[10:8];
               regs_in[REG_FREQ_LO]      = sweep_sum[7:0];
            end
         end
         // Length: count down, and drop the status bit on reaching zero with length enabled.
         if (hits.length && (len != '0)) begin
            regs_in[REG_LENGTH][5:0] = len - 1'b1;
            if (regs_ff[REG_FREQ_HI][6] && (len == 6'd1)) begin
               regs_in[REG_STATUS][0] = 1'b0;
            end
         end
         // Envelope: one volume step within the nibble range.
         if (hits.envelope) begin
            if (!env_up && (vol != 4'd0)) begin
               regs_in[REG_ENVELOPE][7:4] = vol - 1'b1;
            end else if (env_up && (vol != 4'd15)) begin
               regs_in[REG_ENVELOPE][7:4] = vol + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign rd_data = (index < REG_IDX_BITS'(REG_COUNT)) ? regs_ff[index] : 8'h00;

   assign view.run         = regs_ff[REG_FREQ_HI][7];
   assign view.sweep_pace  = regs_ff[REG_SWEEP][6:4];
   assign view.sweep_exp   = regs_ff[REG_SWEEP][2:0];
   assign view.env_length  = regs_ff[REG_ENVELOPE][2:0];
   assign view.volume      = vol;
   assign view.frequency   = freq;
   assign view.status_on   = regs_ff[REG_STATUS][0];

endmodule

// ===== dv/square_channel_sweep_length_envelope_unit_tb.sv =====
`timescale 1ns / 1ps

module square_channel_sweep_length_envelope_unit_tb;
   import sqc_pkg::*;

   localparam int unsigned COUNTER_BITS     = CYCLE_BITS_DEFAULT;
   localparam int unsigned RANDOM_WORDS     = 400;
   localparam int unsigned UNPACED_WORDS    = 60;
   localparam int unsigned HOLD_OFF_AT      = 120;
   localparam int unsigned DRAIN_AT         = 260;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES    = 60;
   localparam int unsigned MAX_SHOWN        = 10;

   // Codes that the block must treat as no-ops.
   localparam logic [1:0]  CMD_UNUSED  = 2'd3;
   localparam logic [2:0]  REG_NONE_LO = 3'd6;
   localparam logic [2:0]  REG_NONE_HI = 3'd7;

   // Periods in clock cycles.
   localparam logic [63:0] SWEEP_UNIT_CYCLES  = 4194304 / 128;
   localparam logic [63:0] LENGTH_CYCLES      = 4194304 / 256;
   localparam logic [63:0] ENV_UNIT_CYCLES    = 4194304 / 64;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  reg_index;
      logic [7:0]  write_data;
      logic [15:0] cycles;
   } chan_word_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        channel_running;
      logic [3:0]  volume;
      logic [10:0] frequency;
      logic        status_on;
   } chan_status_type;

   typedef struct packed {
      chan_word_type   word;
      logic            typed;
      chan_status_type status;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   sqc_req_if req_ch ();
   sqc_rsp_if rsp_ch ();

   square_channel_sweep_length_envelope_unit #(
      .CYCLE_COUNTER_BITS(COUNTER_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the channel registers and the running cycle total.
   logic [7:0]   shadow_regs [REG_COUNT];
   logic [63:0]  shadow_total;

   chan_status_type pending_status [$];
   int unsigned     fault_count = 0;
   bit              hold_off_req = 1'b0;

   always #5 clock = ~clock;

   function automatic logic period_crossed(logic [63:0] from_total, logic [63:0] to_total,
                                           logic [63:0] period);
      return (to_total / period) > (from_total / period);
   endfunction

   // Time advance: sweep, then length, then envelope, all on the same span.
   function automatic void advance_channel(logic [15:0] cyc);
      logic [63:0] cnt_mask;
      logic [63:0] from_total;
      logic [63:0] to_total;
      logic [63:0] sweep_period;
      logic [63:0] env_period;
      int unsigned shift;
      int unsigned freq;
      int unsigned len;
      int unsigned vol;
      cnt_mask = {64{1'b1}} >> (64 - COUNTER_BITS);
      if (!shadow_regs[REG_FREQ_HI][7]) begin
         shadow_total = '0;
         return;
      end
      from_total = shadow_total;
      to_total   = (from_total + 64'(cyc)) & cnt_mask;

      // Sweep moves the frequency; going past the limit stops the channel.
      sweep_period = 64'(shadow_regs[REG_SWEEP][6:4]) * SWEEP_UNIT_CYCLES;
      shift        = 32'(shadow_regs[REG_SWEEP][2:0]);
      if (sweep_period != 0 && shift != 0 &&
          period_crossed(from_total, to_total, sweep_period)) begin
         freq = 32'({shadow_regs[REG_FREQ_HI][2:0], shadow_regs[REG_FREQ_LO]});
         if (shadow_regs[REG_SWEEP][3]) begin
            freq = freq - (freq >> shift);
         end else begin
            freq = freq + (freq >> shift);
         end
         if (freq < FREQ_LIMIT) begin
            shadow_regs[REG_FREQ_HI][2:0] = freq[10:8];
            shadow_regs[REG_FREQ_LO]      = freq[7:0];
         end else begin
            shadow_regs[REG_FREQ_HI][7] = 1'b0;
         end
      end

      // Length count runs down; at zero with length enabled the status drops.
      if (period_crossed(from_total, to_total, LENGTH_CYCLES)) begin
         len = 32'(shadow_regs[REG_LENGTH][5:0]);
         if (len != 0) begin
            len = len - 1;
            shadow_regs[REG_LENGTH][5:0] = len[5:0];
            if (shadow_regs[REG_FREQ_HI][6] && len == 0) begin
               shadow_regs[REG_STATUS][0] = 1'b0;
            end
         end
      end

      // Envelope steps the volume by one, saturating at both ends.
      env_period = 64'(shadow_regs[REG_ENVELOPE][2:0]) * ENV_UNIT_CYCLES;
      if (env_period != 0 && period_crossed(from_total, to_total, env_period)) begin
         vol = 32'(shadow_regs[REG_ENVELOPE][7:4]);
         if (!shadow_regs[REG_ENVELOPE][3] && vol != 0) begin
            vol = vol - 1;
         end else if (shadow_regs[REG_ENVELOPE][3] && vol < 15) begin
            vol = vol + 1;
         end
         shadow_regs[REG_ENVELOPE][7:4] = vol[3:0];
      end

      shadow_total = to_total;
   endfunction

   // Applies one word to the shadow state and returns the status it leaves.
   function automatic chan_status_type predict_status(chan_word_type w);
      chan_status_type s;
      s.read_data = '0;
      case (w.command)
         CMD_ADVANCE: begin
            advance_channel(w.cycles);
         end
         CMD_WRITE: begin
            if (w.reg_index < REG_COUNT) begin
               shadow_regs[w.reg_index] = w.write_data;
            end
         end
         CMD_READ: begin
            if (w.reg_index < REG_COUNT) begin
               s.read_data = shadow_regs[w.reg_index];
            end
         end
         default: begin
         end
      endcase
      s.channel_running = shadow_regs[REG_FREQ_HI][7];
      s.volume          = shadow_regs[REG_ENVELOPE][7:4];
      s.frequency       = {shadow_regs[REG_FREQ_HI][2:0], shadow_regs[REG_FREQ_LO]};
      s.status_on       = shadow_regs[REG_STATUS][0];
      return s;
   endfunction

   function automatic dir_row_type make_row(logic [1:0] cmd, logic [2:0] idx,
                                            logic [7:0] data,
                                            logic [15:0] cyc, logic typed = 1'b0,
                                            logic [7:0] rd = '0, logic run = 1'b0,
                                            logic [3:0] vol = '0, logic [10:0] freq = '0,
                                            logic st = 1'b0);
      dir_row_type r;
      r.word   = '{command: cmd, reg_index: idx, write_data: data, cycles: cyc};
      r.typed  = typed;
      r.status = '{read_data: rd, channel_running: run, volume: vol, frequency: freq,
                   status_on: st};
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(20, 60);
   endfunction

   // Random word: mostly advances and writes that keep the channel running.
   function automatic chan_word_type random_word();
      chan_word_type w;
      int unsigned   pick;
      w.command    = CMD_ADVANCE;
      w.reg_index  = 3'($urandom_range(0, 7));
      w.write_data = 8'($urandom_range(0, 255));
      w.cycles     = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         if ($urandom_range(0, 3) == 0) begin
            w.cycles = 16'($urandom_range(0, 4095));
         end
      end else if (pick < 80) begin
         w.command   = CMD_WRITE;
         w.reg_index = 3'($urandom_range(REG_SWEEP, REG_STATUS));
         if (w.reg_index == REG_FREQ_HI && $urandom_range(0, 3) != 0) begin
            w.write_data[7] = 1'b1;
         end
         if (w.reg_index == REG_LENGTH && $urandom_range(0, 1) == 1) begin
            w.write_data[5:2] = '0;
         end
      end else if (pick < 95) begin
         w.command   = CMD_READ;
         w.reg_index = 3'($urandom_range(REG_SWEEP, REG_STATUS));
      end else if ($urandom_range(0, 1) == 1) begin
         w.command = CMD_UNUSED;
      end else begin
         w.command   = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
         w.reg_index = 3'($urandom_range(REG_NONE_LO, REG_NONE_HI));
      end
      return w;
   endfunction

   // Offers one word, waits for it to be taken, then records its expected status.
   task automatic send_word(chan_word_type w, logic typed, chan_status_type typed_status);
      chan_status_type predicted;
      req_ch.valid      <= 1'b1;
      req_ch.command    <= w.command;
      req_ch.reg_index  <= w.reg_index;
      req_ch.write_data <= w.write_data;
      req_ch.cycles     <= w.cycles;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = predict_status(w);
      pending_status.push_back(typed ? typed_status : predicted);
   endtask

   task automatic idle_sender(int unsigned n);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Sender: reset, directed table, then random words.
   initial begin
      dir_row_type     rows [$];
      chan_status_type no_status;
      int unsigned     i;
      no_status         = '0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.command    = '0;
      req_ch.reg_index  = '0;
      req_ch.write_data = '0;
      req_ch.cycles     = '0;
      for (i = 0; i < REG_COUNT; i++) begin
         shadow_regs[i] = '0;
      end
      shadow_total = '0;

      // After reset, bad indexes and unused codes all read back as zero.
      rows.push_back(make_row(CMD_READ,    REG_SWEEP,    8'h00, 16'h0000, 1'b1));
      rows.push_back(make_row(CMD_READ,    REG_NONE_LO,  8'h5a, 16'h0000, 1'b1));
      rows.push_back(make_row(CMD_WRITE,   REG_NONE_HI,  8'hff, 16'h0000, 1'b1));
      rows.push_back(make_row(CMD_UNUSED,  REG_FREQ_HI,  8'hff, 16'hffff, 1'b1));
      rows.push_back(make_row(CMD_ADVANCE, REG_STATUS,   8'hff, 16'hffff, 1'b1));
      // Load every register near its top value and start the channel.
      rows.push_back(make_row(CMD_WRITE, REG_ENVELOPE, 8'hf7, 16'h0000, 1'b1,
                              8'h00, 1'b0, 4'hf, 11'h000, 1'b0));
      rows.push_back(make_row(CMD_WRITE, REG_SWEEP,    8'h77, 16'h0000, 1'b1,
                              8'h00, 1'b0, 4'hf, 11'h000, 1'b0));
      rows.push_back(make_row(CMD_WRITE, REG_LENGTH,   8'hff, 16'h0000, 1'b1,
                              8'h00, 1'b0, 4'hf, 11'h000, 1'b0));
      rows.push_back(make_row(CMD_WRITE, REG_FREQ_LO,  8'hff, 16'h0000, 1'b1,
                              8'h00, 1'b0, 4'hf, 11'h0ff, 1'b0));
      rows.push_back(make_row(CMD_WRITE, REG_FREQ_HI,  8'hc7, 16'h0000, 1'b1,
                              8'h00, 1'b1, 4'hf, 11'h7ff, 1'b0));
      rows.push_back(make_row(CMD_WRITE, REG_STATUS,   8'h01, 16'h0000, 1'b1,
                              8'h00, 1'b1, 4'hf, 11'h7ff, 1'b1));
      // Long advances until the upward sweep overflows and stops the channel.
      repeat (4) rows.push_back(make_row(CMD_ADVANCE, REG_SWEEP, 8'h00, 16'hffff));
      rows.push_back(make_row(CMD_READ,  REG_FREQ_HI,  8'h00, 16'h0000));
      rows.push_back(make_row(CMD_READ,  REG_LENGTH,   8'h00, 16'h0000));
      // Downward sweep, rising envelope, length running out with length enabled.
      rows.push_back(make_row(CMD_WRITE, REG_SWEEP,    8'h1f, 16'h0000));
      rows.push_back(make_row(CMD_WRITE, REG_ENVELOPE, 8'h09, 16'h0000));
      rows.push_back(make_row(CMD_WRITE, REG_LENGTH,   8'h01, 16'h0000));
      rows.push_back(make_row(CMD_WRITE, REG_FREQ_HI,  8'hc0, 16'h0000));
      rows.push_back(make_row(CMD_ADVANCE, REG_SWEEP,  8'h00, 16'hffff));
      rows.push_back(make_row(CMD_ADVANCE, REG_SWEEP,  8'h00, 16'h0000));
      // Zero shift disables the sweep; then stop the channel with an all-zero byte.
      rows.push_back(make_row(CMD_WRITE, REG_SWEEP,    8'h70, 16'h0000));
      rows.push_back(make_row(CMD_READ,  REG_STATUS,   8'h00, 16'h0000));
      rows.push_back(make_row(CMD_WRITE, REG_FREQ_HI,  8'h00, 16'h0000));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[r]) begin
         send_word(rows[r].word, rows[r].typed, rows[r].status);
         idle_sender(pick_gap());
      end

      for (i = 0; i < RANDOM_WORDS; i++) begin
         // Let the receiver back up while words keep coming.
         if (i == HOLD_OFF_AT) begin
            hold_off_req = 1'b1;
         end
         // Stop and let every outstanding word drain.
         if (i == DRAIN_AT) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (pending_status.size() != 0);
         end
         send_word(random_word(), 1'b0, no_status);
         if (i >= UNPACED_WORDS) begin
            idle_sender(pick_gap());
         end
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_status.size() == 0) begin
         $display("PASS square_channel_sweep_length_envelope_unit");
      end else begin
         $display("FAIL square_channel_sweep_length_envelope_unit");
      end
      $finish;
   end

   // Receiver: random ready with one long hold-off on request.
   initial begin
      int unsigned span;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if ($urandom_range(0, 99) < 60) begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 20);
            rsp_ch.ready <= 1'b1;
            repeat (span) @(posedge clock);
         end else begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 3);
            rsp_ch.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end
      end
   end

   // Compare each accepted result word with the oldest expected status.
   always @(posedge clock) begin
      chan_status_type got;
      chan_status_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.read_data       = rsp_ch.read_data;
         got.channel_running = rsp_ch.channel_running;
         got.volume          = rsp_ch.volume;
         got.frequency       = rsp_ch.frequency;
         got.status_on       = rsp_ch.status_on;
         if (pending_status.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_SHOWN) begin
               $display("%t: result word with nothing expected: rd=%h run=%b vol=%h f=%h st=%b",
                        $realtime, got.read_data, got.channel_running, got.volume,
                        got.frequency, got.status_on);
            end
         end else begin
            want = pending_status.pop_front();
            if (got.read_data !== want.read_data ||
                got.channel_running !== want.channel_running ||
                got.volume !== want.volume ||
                got.frequency !== want.frequency ||
                got.status_on !== want.status_on) begin
               fault_count++;
               if (fault_count <= MAX_SHOWN) begin
                  $display("%t: mismatch exp rd=%h run=%b vol=%h f=%h st=%b", $realtime,
                           want.read_data, want.channel_running, want.volume,
                           want.frequency, want.status_on);
                  $display("%t:          got rd=%h run=%b vol=%h f=%h st=%b", $realtime,
                           got.read_data, got.channel_running, got.volume,
                           got.frequency, got.status_on);
               end
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("FAIL square_channel_sweep_length_envelope_unit");
      $finish;
   end

endmodule
